FILE: hdl/uhg_pkg.sv
`timescale 1ns / 1ps
package uhg_pkg;

   localparam int MAX_PAYLOAD      = 2048;
   localparam int COUNT_W          = $clog2(MAX_PAYLOAD + 1);
   localparam int UDP_HDR_BYTES    = 8;
   localparam int IP_UDP_HDR_BYTES = 28;
   localparam int HDR_WORDS        = 7;
   localparam int IDX_W            = 3;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int SUM_STEPS        = 5;
   localparam int STEP_W           = $clog2(SUM_STEPS);
   localparam int CSR_IDX_W        = 3;

   localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
   localparam logic [7:0]  MAXTTL         = 8'hFF;
   localparam logic [7:0]  UDP_PROTOCOL   = 8'h11;
   localparam logic [15:0] ALL_ONES       = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_ADDR  = 3'd0,
      CSR_DST_ADDR  = 3'd1,
      CSR_SRC_PORT  = 3'd2,
      CSR_DST_PORT  = 3'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SUM,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic       end_of_payload;
   } req_type;

   typedef struct packed {
      logic [31:0]      header_word;
      logic [IDX_W-1:0] word_index;
      logic             final_word;
      logic             too_long;
   } rsp_type;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        sum;
      logic [COUNT_W-1:0] count;
      logic               too_long;
   } pkt_type;

   function automatic logic [15:0] oc_add3(input logic [15:0] a,
                                           input logic [15:0] b,
                                           input logic [15:0] c);
      logic [17:0] s;
      logic [16:0] t;
      s = {2'b00, a} + {2'b00, b} + {2'b00, c};
      t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
      return t[15:0] + {15'd0, t[16]};
   endfunction

endpackage

FILE: hdl/udp_ipv4_header_generator.sv
`timescale 1ns / 1ps
// Payload bytes are taken one per cycle while the summary queue is not full; the running checksum
// add, byte count and odd-byte hold are the per-byte work. The closing transaction queues a
// packet summary (4 deep); the back end loads it, then steps through its sum states feeding two
// three-input ones'-complement adders (UDP and IPv4), then emits the seven header words, held
// while the output is stalled. Synchronous active-high reset clears the running state, queue,
// back-end state and all configuration registers to zero.
module udp_ipv4_header_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  uhg_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output uhg_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [uhg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                       csr_data
);

   uhg_pkg::cfg_type cfg_ff, cfg_in;
   uhg_pkg::pkt_type push_pkt, pop_pkt;
   logic             push, pop, q_full, q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            uhg_pkg::CSR_SRC_ADDR: cfg_in.source_address      = csr_data;
            uhg_pkg::CSR_DST_ADDR: cfg_in.destination_address = csr_data;
            uhg_pkg::CSR_SRC_PORT: cfg_in.source_port         = csr_data[15:0];
            uhg_pkg::CSR_DST_PORT: cfg_in.destination_port    = csr_data[15:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uhg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_pkt  (push_pkt)
   );

   uhg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pkt (push_pkt),
      .pop      (pop),
      .pop_pkt  (pop_pkt),
      .q_full   (q_full),
      .q_empty  (q_empty)
   );

   uhg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .pop_pkt   (pop_pkt),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: hdl/uhg_front.sv
`timescale 1ns / 1ps
module uhg_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  uhg_pkg::req_type req_data,
   input  logic             q_full,
   output logic             push,
   output uhg_pkg::pkt_type push_pkt
);

   logic [15:0]                 sum_ff, sum_in;
   logic [7:0]                  held_ff, held_in;
   logic                        pend_ff, pend_in;
   logic [uhg_pkg::COUNT_W-1:0] cnt_ff, cnt_in;
   logic                        ovf_ff, ovf_in;

   logic        accept;
   logic        at_limit;
   logic        take;
   logic        add_now;
   logic [15:0] operand;
   logic [15:0] sum_next;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign at_limit  = cnt_ff >= uhg_pkg::COUNT_W'(uhg_pkg::MAX_PAYLOAD);
   assign take      = accept && req_data.byte_valid && !at_limit;
   assign push      = accept && req_data.end_of_payload;

   always_comb begin
      operand = 16'd0;
      add_now = 1'b0;
      if (take && pend_ff) begin
         operand = {held_ff, req_data.payload_byte};
         add_now = 1'b1;
      end else if (push) begin
         // pad the trailing odd byte with zero
         add_now = 1'b1;
         if (take) begin
            operand = {req_data.payload_byte, 8'd0};
         end else if (pend_ff) begin
            operand = {held_ff, 8'd0};
         end
      end
   end

   assign sum_next = add_now ? uhg_pkg::oc_add3(sum_ff, operand, 16'd0) : sum_ff;

   always_comb begin
      push_pkt.sum      = sum_next;
      push_pkt.count    = take ? cnt_ff + uhg_pkg::COUNT_W'(1) : cnt_ff;
      push_pkt.too_long = ovf_ff || (accept && req_data.byte_valid && at_limit);
   end

   always_comb begin
      sum_in  = sum_ff;
      held_in = held_ff;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      if (push) begin
         sum_in  = 16'd0;
         held_in = 8'd0;
         pend_in = 1'b0;
         cnt_in  = '0;
         ovf_in  = 1'b0;
      end else if (accept && req_data.byte_valid) begin
         if (at_limit) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in  = cnt_ff + uhg_pkg::COUNT_W'(1);
            sum_in  = sum_next;
            pend_in = !pend_ff;
            if (!pend_ff) begin
               held_in = req_data.payload_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= 16'd0;
         held_ff <= 8'd0;
         pend_ff <= 1'b0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         held_ff <= held_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         ovf_ff  <= ovf_in;
      end
   end

endmodule

FILE: hdl/uhg_queue.sv
`timescale 1ns / 1ps
module uhg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  uhg_pkg::pkt_type push_pkt,
   input  logic             pop,
   output uhg_pkg::pkt_type pop_pkt,
   output logic             q_full,
   output logic             q_empty
);

   uhg_pkg::pkt_type              mem_ff [uhg_pkg::QUEUE_DEPTH];
   logic [uhg_pkg::QPTR_W-1:0]    wr_ff, wr_in;
   logic [uhg_pkg::QPTR_W-1:0]    rd_ff, rd_in;
   logic [uhg_pkg::QPTR_W:0]      cnt_ff, cnt_in;

   assign q_full  = cnt_ff == (uhg_pkg::QPTR_W + 1)'(uhg_pkg::QUEUE_DEPTH);
   assign q_empty = cnt_ff == '0;
   assign pop_pkt = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + uhg_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + uhg_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + (uhg_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (uhg_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_pkt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hdl/uhg_back.sv
`timescale 1ns / 1ps
module uhg_back (
   input  logic             clock,
   input  logic             reset,
   input  uhg_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  uhg_pkg::pkt_type pop_pkt,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output uhg_pkg::rsp_type rsp_data
);

   uhg_pkg::back_state_type      st_ff, st_in;
   logic [uhg_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [uhg_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [15:0]                  udp_acc_ff, udp_acc_in;
   logic [15:0]                  ip_acc_ff, ip_acc_in;
   logic [15:0]                  udp_len_ff, udp_len_in;
   logic [15:0]                  tot_len_ff, tot_len_in;
   logic                         ovf_ff, ovf_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   uhg_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic        slot_free;
   logic        emit;
   logic        last_step;
   logic        last_word;
   logic [15:0] udp_a, udp_b, ip_a, ip_b;
   logic [15:0] udp_ck_raw, udp_ck, ip_ck;
   logic [31:0] word;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_step = step_ff == uhg_pkg::STEP_W'(uhg_pkg::SUM_STEPS - 1);
   assign last_word = idx_ff == uhg_pkg::IDX_W'(uhg_pkg::HDR_WORDS - 1);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         uhg_pkg::BK_IDLE: begin
            if (!q_empty) begin
               st_in = uhg_pkg::BK_SUM;
            end
         end
         uhg_pkg::BK_SUM: begin
            if (last_step) begin
               st_in = uhg_pkg::BK_EMIT;
            end
         end
         uhg_pkg::BK_EMIT: begin
            if (slot_free && last_word) begin
               st_in = uhg_pkg::BK_IDLE;
            end
         end
         default: st_in = uhg_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop  = (st_ff == uhg_pkg::BK_IDLE) && !q_empty;
      emit = (st_ff == uhg_pkg::BK_EMIT) && slot_free;
   end

   always_comb begin
      udp_a = 16'd0;
      udp_b = 16'd0;
      ip_a  = 16'd0;
      ip_b  = 16'd0;
      case (step_ff)
         3'd0: begin
            udp_a = cfg.source_address[31:16];
            udp_b = cfg.source_address[15:0];
            ip_a  = uhg_pkg::IP_VER_IHL_TOS;
            ip_b  = tot_len_ff;
         end
         3'd1: begin
            udp_a = cfg.destination_address[31:16];
            udp_b = cfg.destination_address[15:0];
            ip_a  = {uhg_pkg::MAXTTL, uhg_pkg::UDP_PROTOCOL};
         end
         3'd2: begin
            udp_a = {8'd0, uhg_pkg::UDP_PROTOCOL};
            udp_b = udp_len_ff;
            ip_a  = cfg.source_address[31:16];
            ip_b  = cfg.source_address[15:0];
         end
         3'd3: begin
            udp_a = cfg.source_port;
            udp_b = cfg.destination_port;
            ip_a  = cfg.destination_address[31:16];
            ip_b  = cfg.destination_address[15:0];
         end
         3'd4: begin
            udp_a = udp_len_ff;
         end
         default: begin
            udp_a = 16'd0;
         end
      endcase
   end

   assign udp_ck_raw = ~udp_acc_ff;
   assign udp_ck     = (udp_ck_raw == 16'd0) ? uhg_pkg::ALL_ONES : udp_ck_raw;
   assign ip_ck      = ~ip_acc_ff;

   always_comb begin
      case (idx_ff)
         3'd0:    word = {uhg_pkg::IP_VER_IHL_TOS, tot_len_ff};
         3'd1:    word = 32'd0;
         3'd2:    word = {uhg_pkg::MAXTTL, uhg_pkg::UDP_PROTOCOL, ip_ck};
         3'd3:    word = cfg.source_address;
         3'd4:    word = cfg.destination_address;
         3'd5:    word = {cfg.source_port, cfg.destination_port};
         3'd6:    word = {udp_len_ff, udp_ck};
         default: word = 32'd0;
      endcase
   end

   always_comb begin
      step_in    = step_ff;
      idx_in     = idx_ff;
      udp_acc_in = udp_acc_ff;
      ip_acc_in  = ip_acc_ff;
      udp_len_in = udp_len_ff;
      tot_len_in = tot_len_ff;
      ovf_in     = ovf_ff;
      if (pop) begin
         step_in    = '0;
         idx_in     = '0;
         udp_acc_in = pop_pkt.sum;
         ip_acc_in  = 16'd0;
         udp_len_in = 16'(pop_pkt.count) + 16'(uhg_pkg::UDP_HDR_BYTES);
         tot_len_in = 16'(pop_pkt.count) + 16'(uhg_pkg::IP_UDP_HDR_BYTES);
         ovf_in     = pop_pkt.too_long;
      end else if (st_ff == uhg_pkg::BK_SUM) begin
         step_in    = step_ff + uhg_pkg::STEP_W'(1);
         udp_acc_in = uhg_pkg::oc_add3(udp_acc_ff, udp_a, udp_b);
         ip_acc_in  = uhg_pkg::oc_add3(ip_acc_ff, ip_a, ip_b);
      end else if (emit) begin
         idx_in = idx_ff + uhg_pkg::IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (slot_free) begin
         rsp_valid_in = emit;
      end
      if (emit) begin
         rsp_data_in.header_word = word;
         rsp_data_in.word_index  = idx_ff;
         rsp_data_in.final_word  = last_word;
         rsp_data_in.too_long    = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      idx_ff     <= idx_in;
      udp_acc_ff <= udp_acc_in;
      ip_acc_ff  <= ip_acc_in;
      udp_len_ff <= udp_len_in;
      tot_len_ff <= tot_len_in;
      ovf_ff     <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= uhg_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/uhg_checker.sv
`timescale 1ns / 1ps
module uhg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input uhg_pkg::rsp_type              rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.final_word == (rsp_data.word_index == 3'd6)))
      else $error("final_word does not match last index");

   a_word0: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_index == 3'd0 |-> rsp_data.header_word[31:16] == 16'h4500)
      else $error("bad version/IHL word");

   a_word2: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_index == 3'd2 |-> rsp_data.header_word[31:16] == 16'hFF11)
      else $error("bad TTL/protocol word");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind udp_ipv4_header_generator uhg_checker u_uhg_checker (.*);
